>>> src/anti_replay_window_unit_defines.svh
// ----------------------------------------------------------------------------
// anti_replay_window_unit_defines.svh
// Assertion macros used by the anti-replay window unit RTL
// ----------------------------------------------------------------------------
`ifndef ANTI_REPLAY_WINDOW_UNIT_DEFINES_SVH
`define ANTI_REPLAY_WINDOW_UNIT_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define ARW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define ARW_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> src/arw_pkg.sv
// ----------------------------------------------------------------------------
// arw_pkg
// Verdict codes, limits and shared types of the anti-replay window unit
// ----------------------------------------------------------------------------
`default_nettype none

package arw_pkg;

  // verdict codes carried by the result word
  localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
  localparam logic [2:0] VERDICT_EXHAUSTED = 3'd1;
  localparam logic [2:0] VERDICT_TOO_OLD   = 3'd2;
  localparam logic [2:0] VERDICT_DUPLICATE = 3'd3;
  localparam logic [2:0] VERDICT_CLEARED   = 3'd4;

  // counters at or above this value are refused (2^64 - 2^13 - 2)
  localparam logic [63:0] REJECT_LIMIT = 64'hFFFF_FFFF_FFFF_DFFE;

  // outcome of one window check
  typedef struct packed {
    logic [2:0] verdict;
    logic       advance;   // counter is newer than the highest seen
    logic       wr_en;     // write the updated block back
  } check_res_t;

endpackage

`default_nettype wire

>>> src/arw_bitmap_ram.sv
// ----------------------------------------------------------------------------
// arw_bitmap_ram
// Single-port-write, single-port-read synchronous memory for the window blocks
// ----------------------------------------------------------------------------
`default_nettype none

module arw_bitmap_ram #(
  parameter int ADDR_BITS = 7,
  parameter int DATA_BITS = 115
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0] wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/arw_check.sv
// ----------------------------------------------------------------------------
// arw_check
// Decides the verdict for one counter and builds the updated window block
// ----------------------------------------------------------------------------
`default_nettype none

module arw_check #(
  parameter  int BLOCK_BITS = 64,
  parameter  int NUM_BLOCKS = 128,
  localparam int LB         = $clog2(BLOCK_BITS),
  localparam int LN         = $clog2(NUM_BLOCKS),
  localparam int TAG_BITS   = 64 - LB - LN,
  localparam int ENTRY_BITS = TAG_BITS + BLOCK_BITS
) (
  input  wire logic [63:0]             cval,
  input  wire logic [63:0]             highest,
  input  wire logic                    exhausted,
  input  wire logic                    too_old,
  input  wire logic [ENTRY_BITS-1:0]   rd_entry,
  output arw_pkg::check_res_t          res,
  output logic      [ENTRY_BITS-1:0]   wr_entry
);

  logic [TAG_BITS-1:0]   tag;
  logic [LB-1:0]         bitpos;
  logic                  match;
  logic [BLOCK_BITS-1:0] old_bits;
  logic [BLOCK_BITS-1:0] bit_mask;
  logic                  dup;

  // stored tag names the block that the slot holds; any other block reads as zero
  always_comb begin
    tag      = cval[63 -: TAG_BITS];
    bitpos   = cval[LB-1:0];
    match    = (rd_entry[ENTRY_BITS-1 -: TAG_BITS] == tag);
    old_bits = match ? rd_entry[BLOCK_BITS-1:0] : '0;
    bit_mask = {{(BLOCK_BITS-1){1'b0}}, 1'b1} << bitpos;
    dup      = |(old_bits & bit_mask);
    wr_entry = {tag, old_bits | bit_mask};
  end

  // verdict in rule order
  always_comb begin
    res.advance = (cval > highest);
    res.wr_en   = 1'b0;
    if (exhausted) begin
      res.verdict = arw_pkg::VERDICT_EXHAUSTED;
      res.advance = 1'b0;
    end else if (too_old) begin
      res.verdict = arw_pkg::VERDICT_TOO_OLD;
      res.advance = 1'b0;
    end else if (dup) begin
      res.verdict = arw_pkg::VERDICT_DUPLICATE;
    end else begin
      res.verdict = arw_pkg::VERDICT_ACCEPT;
      res.wr_en   = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> src/anti_replay_window_unit.sv
// ----------------------------------------------------------------------------
// anti_replay_window_unit
// Sliding-bitmap anti-replay check for 64-bit transport packet counters
// ----------------------------------------------------------------------------
// A counter check reads the addressed block in the lookup state, then decides
// and writes the updated block back in the decide state, which waits while
// the result register is held by a stalled output; the next word is taken
// only after the result is registered, so checks do not overlap. This is set
// by the read-modify-write of the single block memory. A window clear zeroes
// one block per cycle through the memory write port, and the same clearing
// pass runs after reset before the first word is taken. Each memory slot
// keeps the number of the block it holds, so blocks skipped when the window
// advances need no zeroing. BLOCK_BITS and NUM_BLOCKS must be powers of two.
`default_nettype none
`include "anti_replay_window_unit_defines.svh"

module anti_replay_window_unit #(
  parameter int BLOCK_BITS = 64,
  parameter int NUM_BLOCKS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [63:0] counter,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       verdict
);

  localparam int LB         = $clog2(BLOCK_BITS);
  localparam int LN         = $clog2(NUM_BLOCKS);
  localparam int TAG_BITS   = 64 - LB - LN;
  localparam int ENTRY_BITS = TAG_BITS + BLOCK_BITS;

  localparam logic [63:0]   WINDOW_SPAN = 64'(BLOCK_BITS) * 64'(NUM_BLOCKS - 1);
  localparam logic [LN-1:0] LAST_SLOT   = LN'(NUM_BLOCKS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_CLEAR  = 2'd3;

  logic [1:0]            state;
  logic [63:0]           cval;
  logic                  exhausted;
  logic                  too_old;
  logic [63:0]           highest;
  logic [LN-1:0]         clr_idx;
  logic                  clr_report;

  logic                  out_free;
  logic                  out_load;
  logic                  mem_wr_en;
  logic [LN-1:0]         mem_wr_addr;
  logic [ENTRY_BITS-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [ENTRY_BITS-1:0] mem_rd_data;
  logic [ENTRY_BITS-1:0] upd_entry;
  arw_pkg::check_res_t   check_res;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // a result word is loaded on a decide or at the end of a reported clear
  assign out_load = out_free && ((state == ST_DECIDE) ||
                    ((state == ST_CLEAR) && (clr_idx == LAST_SLOT) && clr_report));

  // block memory
  arw_bitmap_ram #(
    .ADDR_BITS (LN),
    .DATA_BITS (ENTRY_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (cval[LB +: LN]),
    .rd_data (mem_rd_data)
  );

  // verdict and updated block
  arw_check #(
    .BLOCK_BITS (BLOCK_BITS),
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_check (
    .cval      (cval),
    .highest   (highest),
    .exhausted (exhausted),
    .too_old   (too_old),
    .rd_entry  (mem_rd_data),
    .res       (check_res),
    .wr_entry  (upd_entry)
  );

  // memory port control: sweep writes zero, decide writes the updated block
  always_comb begin
    mem_rd_en   = (state == ST_LOOKUP);
    mem_wr_en   = 1'b0;
    mem_wr_addr = cval[LB +: LN];
    mem_wr_data = upd_entry;
    if (state == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_idx;
      mem_wr_data = '0;
    end else if (state == ST_DECIDE) begin
      mem_wr_en = check_res.wr_en && out_free;
    end
  end

  // sequencer, window head and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      clr_report <= 1'b0;
      highest    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cval      <= counter + 64'd1;
            exhausted <= (counter >= arw_pkg::REJECT_LIMIT);
            if (mode) begin
              state      <= ST_CLEAR;
              clr_idx    <= '0;
              clr_report <= 1'b1;
              highest    <= '0;
            end else begin
              state <= ST_LOOKUP;
            end
          end
        end
        ST_LOOKUP: begin
          too_old <= (highest > cval) && ((highest - cval) > WINDOW_SPAN);
          state   <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            verdict <= check_res.verdict;
            if (check_res.advance) begin
              highest <= cval;
            end
            state <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          if (clr_idx == LAST_SLOT) begin
            if (!clr_report) begin
              state <= ST_IDLE;
            end else if (out_free) begin
              verdict <= arw_pkg::VERDICT_CLEARED;
              state   <= ST_IDLE;
            end
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // window head only moves back on a clear
  `ARW_ASSERT(a_highest_monotonic, !(in_valid && !in_stall && mode) |=> (highest >= $past(highest)), "highest counter moved back without a clear")
  // read and write of the block memory never share the lookup cycle
  `ARW_ASSERT_NEVER(a_no_write_in_lookup, (state == ST_LOOKUP) && mem_wr_en, "memory written during block read")
  // a result word appears only after a decide or a reported clear
  `ARW_ASSERT(a_result_source, $rose(out_valid) |-> (($past(state) == ST_DECIDE) || ($past(state) == ST_CLEAR)), "result word raised from wrong state")
  // an accepted counter is always written back
  `ARW_ASSERT(a_accept_writes, ((state == ST_DECIDE) && out_free && (check_res.verdict == arw_pkg::VERDICT_ACCEPT)) |-> mem_wr_en, "accepted counter not recorded")

endmodule

`default_nettype wire
